[hw/rtl/mkd_pkg.sv]
// ----------------------------------------------------------------------------
// mkd_pkg - shared types and constants of the Morse key decoder
// Register codes, configuration bundle, event kinds and the symbol table.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int CFG_W = 16;

    // Register indexes, byte address = 4 * index
    typedef enum logic [1:0] {
        REG_DOT_LIMIT  = 2'd0,
        REG_LETTER_GAP = 2'd1,
        REG_WORD_GAP   = 2'd2
    } t_reg_idx;

    localparam logic [CFG_W-1:0] DOT_LIMIT_RST  = 16'd200;
    localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd1000;
    localparam logic [CFG_W-1:0] WORD_GAP_RST   = 16'd3000;

    typedef struct packed {
        logic [CFG_W-1:0] dot_limit;
        logic [CFG_W-1:0] letter_gap;
        logic [CFG_W-1:0] word_gap;
    } t_cfg;

    typedef enum logic {
        EV_LETTER = 1'b0,
        EV_SPACE  = 1'b1
    } t_ev_kind;

    localparam logic [6:0] CH_UNKNOWN = 7'd63;  // '?'
    localparam logic [6:0] CH_SPACE   = 7'd32;

    // Index is (1 << length) | pattern, dash = 1, newest symbol in bit 0
    function automatic logic [6:0] f_decode(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'd2:    c = 7'd69;  // E
            6'd3:    c = 7'd84;  // T
            6'd4:    c = 7'd73;  // I
            6'd5:    c = 7'd65;  // A
            6'd6:    c = 7'd78;  // N
            6'd7:    c = 7'd77;  // M
            6'd8:    c = 7'd83;  // S
            6'd9:    c = 7'd85;  // U
            6'd10:   c = 7'd82;  // R
            6'd11:   c = 7'd87;  // W
            6'd12:   c = 7'd68;  // D
            6'd13:   c = 7'd75;  // K
            6'd14:   c = 7'd71;  // G
            6'd15:   c = 7'd79;  // O
            6'd16:   c = 7'd72;  // H
            6'd17:   c = 7'd86;  // V
            6'd18:   c = 7'd70;  // F
            6'd20:   c = 7'd76;  // L
            6'd22:   c = 7'd80;  // P
            6'd23:   c = 7'd74;  // J
            6'd24:   c = 7'd66;  // B
            6'd25:   c = 7'd88;  // X
            6'd26:   c = 7'd67;  // C
            6'd27:   c = 7'd89;  // Y
            6'd28:   c = 7'd90;  // Z
            6'd29:   c = 7'd81;  // Q
            6'd32:   c = 7'd53;  // 5
            6'd33:   c = 7'd52;  // 4
            6'd35:   c = 7'd51;  // 3
            6'd39:   c = 7'd50;  // 2
            6'd47:   c = 7'd49;  // 1
            6'd48:   c = 7'd54;  // 6
            6'd56:   c = 7'd55;  // 7
            6'd60:   c = 7'd56;  // 8
            6'd62:   c = 7'd57;  // 9
            6'd63:   c = 7'd48;  // 0
            default: c = CH_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/mkd_front.sv]
// ----------------------------------------------------------------------------
// mkd_front - key timing and symbol collection
// Times presses and gaps, builds the symbol pattern and raises letter or
// space events for the back end.
// ----------------------------------------------------------------------------
module mkd_front #(
    parameter int MAX_SYMBOLS = 5,
    parameter int COUNT_BITS  = 16,
    parameter int CNT_W       = $clog2(MAX_SYMBOLS + 2),
    parameter int EV_W        = 1 + CNT_W + MAX_SYMBOLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_key_down,
    input  mkd_pkg::t_cfg     i_cfg,
    output logic              o_ev_push,
    output logic [EV_W-1:0]   o_ev_data
);

    localparam int CMP_W = (COUNT_BITS > mkd_pkg::CFG_W) ? COUNT_BITS : mkd_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] SYM_MAX  = CNT_W'(MAX_SYMBOLS);
    localparam logic [CNT_W-1:0] SYM_OVFL = CNT_W'(MAX_SYMBOLS + 1);

    logic [COUNT_BITS-1:0]  r_press, n_press;
    logic [COUNT_BITS-1:0]  r_gap, n_gap;
    logic                   r_key_was_down, n_key_was_down;
    logic [MAX_SYMBOLS-1:0] r_pattern, n_pattern;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_letter_pend, n_letter_pend;
    logic                   r_space_pend, n_space_pend;

    logic [MAX_SYMBOLS-1:0] rel_pattern;
    logic [CNT_W-1:0]       rel_count;
    logic [COUNT_BITS-1:0]  gap_base;
    logic                   dash;
    logic                   letter_due, space_due;
    mkd_pkg::t_ev_kind      ev_kind;

    always_comb begin
        dash = CMP_W'(r_press) >= CMP_W'(i_cfg.dot_limit);
        // append the symbol of a press that just ended
        rel_pattern = r_pattern;
        rel_count   = r_count;
        if (r_key_was_down) begin
            if (r_count < SYM_MAX) begin
                rel_pattern = {r_pattern[MAX_SYMBOLS-2:0], dash};
                rel_count   = r_count + CNT_W'(1);
            end else begin
                rel_count   = SYM_OVFL;
            end
        end
        gap_base = r_key_was_down ? '0 : r_gap;
        n_gap    = (gap_base == CNT_MAX) ? CNT_MAX : gap_base + COUNT_BITS'(1);

        letter_due = (CMP_W'(n_gap) > CMP_W'(i_cfg.letter_gap)) && r_letter_pend;
        space_due  = (CMP_W'(n_gap) > CMP_W'(i_cfg.word_gap)) && r_space_pend
                     && !letter_due;
    end

    always_comb begin
        n_press        = r_press;
        n_key_was_down = r_key_was_down;
        n_pattern      = r_pattern;
        n_count        = r_count;
        n_letter_pend  = r_letter_pend;
        n_space_pend   = r_space_pend;
        o_ev_push      = 1'b0;
        ev_kind        = mkd_pkg::EV_LETTER;
        if (i_accept) begin
            if (i_key_down) begin
                n_press        = (r_press == CNT_MAX) ? CNT_MAX : r_press + COUNT_BITS'(1);
                n_key_was_down = 1'b1;
                n_letter_pend  = 1'b1;
                n_space_pend   = 1'b1;
            end else begin
                n_press        = '0;
                n_key_was_down = 1'b0;
                n_pattern      = rel_pattern;
                n_count        = rel_count;
                if (letter_due) begin
                    o_ev_push     = 1'b1;
                    n_pattern     = '0;
                    n_count       = '0;
                    n_letter_pend = 1'b0;
                end else if (space_due) begin
                    o_ev_push    = 1'b1;
                    ev_kind      = mkd_pkg::EV_SPACE;
                    n_space_pend = 1'b0;
                end
            end
        end
        o_ev_data = {ev_kind, rel_count, rel_pattern};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press        <= '0;
            r_gap          <= '0;
            r_key_was_down <= 1'b0;
            r_pattern      <= '0;
            r_count        <= '0;
            r_letter_pend  <= 1'b0;
            r_space_pend   <= 1'b0;
        end else begin
            r_press        <= n_press;
            if (i_accept) begin
                r_gap <= i_key_down ? '0 : n_gap;
            end
            r_key_was_down <= n_key_was_down;
            r_pattern      <= n_pattern;
            r_count        <= n_count;
            r_letter_pend  <= n_letter_pend;
            r_space_pend   <= n_space_pend;
        end
    end

endmodule

[hw/rtl/mkd_fifo.sv]
// ----------------------------------------------------------------------------
// mkd_fifo - small event queue
// Register-based first-in first-out queue between front and back end.
// ----------------------------------------------------------------------------
module mkd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_fill, n_fill;
    logic             do_push, do_pop;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = do_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? f_next(r_rd_ptr) : r_rd_ptr;
        n_fill   = r_fill + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

[hw/rtl/mkd_back.sv]
// ----------------------------------------------------------------------------
// mkd_back - event decode and result register
// Turns queued events into ASCII and holds the oldest result for the sink.
// ----------------------------------------------------------------------------
module mkd_back #(
    parameter int MAX_SYMBOLS = 5,
    parameter int CNT_W       = $clog2(MAX_SYMBOLS + 2),
    parameter int EV_W        = 1 + CNT_W + MAX_SYMBOLS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ev_valid,
    input  logic [EV_W-1:0] i_ev_data,
    output logic            o_ev_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [6:0]      o_char_code
);

    logic                   r_valid;
    logic [6:0]             r_char, n_char;
    mkd_pkg::t_ev_kind      ev_kind;
    logic [CNT_W-1:0]       ev_count;
    logic [MAX_SYMBOLS-1:0] ev_pattern;
    logic [MAX_SYMBOLS+4:0] pat_ext;
    logic [5:0]             idx;
    logic                   known_len;

    assign ev_kind    = mkd_pkg::t_ev_kind'(i_ev_data[EV_W-1]);
    assign ev_count   = i_ev_data[MAX_SYMBOLS +: CNT_W];
    assign ev_pattern = i_ev_data[MAX_SYMBOLS-1:0];
    assign pat_ext    = (MAX_SYMBOLS + 5)'(ev_pattern);

    // take a new event whenever the result register is free or drains now
    assign o_ev_pop    = i_ev_valid && (!r_valid || i_pop);
    assign o_empty     = !r_valid;
    assign o_char_code = r_char;

    always_comb begin
        known_len = (ev_count != '0) && (ev_count <= CNT_W'(5))
                    && (ev_count <= CNT_W'(MAX_SYMBOLS));
        idx = (6'd1 << ev_count[2:0]) | {1'b0, pat_ext[4:0]};
        case (ev_kind)
            mkd_pkg::EV_SPACE:  n_char = mkd_pkg::CH_SPACE;
            mkd_pkg::EV_LETTER: n_char = known_len ? mkd_pkg::f_decode(idx)
                                                   : mkd_pkg::CH_UNKNOWN;
            default:            n_char = mkd_pkg::CH_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_pop) begin
            r_char <= n_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ev_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[hw/rtl/morse_key_decoder.sv]
// ----------------------------------------------------------------------------
// morse_key_decoder - Morse key to ASCII decoder
// Samples one key level per item and delivers decoded letters, digits,
// '?' and word spaces through a queue-style result port.
// ----------------------------------------------------------------------------
// Push one key sample per millisecond tick. The block takes one item per
// clock while full is low: the front end updates its press and gap
// counters and the symbol pattern as it takes each sample, and any letter
// or space it calls for goes into a two-entry event queue. The back end
// decodes the oldest event through a constant table into the result
// register, which holds it until popped. With the result register free,
// a character passes through the event queue and then the result register
// before it is on the result ports. full rises only when the event queue
// is full, i.e. when two events wait behind an undelivered result, so
// three characters are pending. Program dot_limit (0x0), letter_gap (0x4)
// and word_gap (0x8) over the APB port while the block is idle; only the
// low 16 bits of each write are kept, and reads return the current values.
// ----------------------------------------------------------------------------
module morse_key_decoder #(
    parameter int MAX_SYMBOLS = 5,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // key samples
    input  logic        push,
    output logic        full,
    input  logic        i_key_down,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_char_code,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 2);
    localparam int EV_W  = 1 + CNT_W + MAX_SYMBOLS;
    localparam int Q_DEPTH = 2;

    mkd_pkg::t_cfg     r_cfg;
    mkd_pkg::t_reg_idx reg_idx;
    logic              cfg_wr;
    logic              accept;
    logic              ev_push, ev_full, ev_valid, ev_pop;
    logic [EV_W-1:0]   ev_wdata, ev_rdata;

    // ------------------------------------------------------------------
    // Configuration port: no wait states, write on the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = mkd_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_limit  <= mkd_pkg::DOT_LIMIT_RST;
            r_cfg.letter_gap <= mkd_pkg::LETTER_GAP_RST;
            r_cfg.word_gap   <= mkd_pkg::WORD_GAP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mkd_pkg::REG_DOT_LIMIT:  r_cfg.dot_limit  <= pwdata[15:0];
                mkd_pkg::REG_LETTER_GAP: r_cfg.letter_gap <= pwdata[15:0];
                mkd_pkg::REG_WORD_GAP:   r_cfg.word_gap   <= pwdata[15:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mkd_pkg::REG_DOT_LIMIT:  prdata = 32'(r_cfg.dot_limit);
            mkd_pkg::REG_LETTER_GAP: prdata = 32'(r_cfg.letter_gap);
            mkd_pkg::REG_WORD_GAP:   prdata = 32'(r_cfg.word_gap);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: hold off samples only while the event queue is full
    // ------------------------------------------------------------------
    assign full   = ev_full;
    assign accept = push && !full;

    mkd_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS),
        .CNT_W       (CNT_W),
        .EV_W        (EV_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_key_down (i_key_down),
        .i_cfg      (r_cfg),
        .o_ev_push  (ev_push),
        .o_ev_data  (ev_wdata)
    );

    // Event queue between the two halves
    mkd_fifo #(
        .WIDTH (EV_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev_wdata),
        .o_full  (ev_full),
        .i_pop   (ev_pop),
        .o_valid (ev_valid),
        .o_data  (ev_rdata)
    );

    // Back end: decode and hold the oldest result
    mkd_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .CNT_W       (CNT_W),
        .EV_W        (EV_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (ev_valid),
        .i_ev_data   (ev_rdata),
        .o_ev_pop    (ev_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_char_code (o_char_code)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a pressed key never produces an event
    a_press_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_key_down) |-> !ev_push)
        else $error("event raised on a key-down sample");

    // a waiting event reaches the result register once it is free
    a_event_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_valid && (empty || pop)) |=> !empty)
        else $error("queued event not moved to the result register");

    // every delivered result is a space or a printable code up to 'Z'
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_char_code >= 7'd32 && o_char_code <= 7'd90))
        else $error("result code out of range");

    // an event is never offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_push |-> !ev_full)
        else $error("event pushed into a full queue");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the Morse key decoder
// Streams key samples into the block, predicts every letter, digit, '?' and
// word space it should deliver, and compares each popped character in order.
// Covers reset values, symbol timing boundaries, overflow and unknown
// patterns, gap corner cases, back-pressure and random keying over many
// register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          MAX_SYM      = 5;
    localparam logic [15:0] COUNT_SAT    = 16'hFFFF;
    localparam logic [3:0]  ADDR_SPARE   = 4'hC;     // beyond the register map
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 1_500_000;
    localparam int          RANDOM_ITEMS = 600;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        r_push    = 1'b0;
    logic        r_key     = 1'b0;
    logic        r_pop     = 1'b0;
    logic        r_psel    = 1'b0;
    logic        r_penable = 1'b0;
    logic        r_pwrite  = 1'b0;
    logic [3:0]  r_paddr   = '0;
    logic [31:0] r_pwdata  = '0;
    logic        full;
    logic        empty;
    logic [6:0]  o_char_code;
    logic [31:0] prdata;
    logic        pready;

    // Decoder state as the bench believes it to be
    mkd_pkg::t_cfg cfg_model;
    logic [15:0]   press_cnt;
    logic [15:0]   gap_cnt;
    logic          key_held;
    logic          letter_due;
    logic          space_due;
    logic [4:0]    sym_bits;
    int unsigned   sym_cnt;
    logic [6:0]    chars_due[$];

    int unsigned items_sent    = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned full_stalls   = 0;
    int unsigned settings_used = 0;
    int unsigned cycles        = 0;
    int          rx_hold       = 0;
    bit          gaps_on       = 1'b1;

    morse_key_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (r_push),
        .full        (full),
        .i_key_down  (r_key),
        .empty       (empty),
        .pop         (r_pop),
        .o_char_code (o_char_code),
        .psel        (r_psel),
        .penable     (r_penable),
        .pwrite      (r_pwrite),
        .paddr       (r_paddr),
        .pwdata      (r_pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [3:0] reg_addr(input mkd_pkg::t_reg_idx r);
        return {r, 2'b00};
    endfunction

    // Advance the predicted decoder by one key sample and queue any character
    // it should produce. The tree string is indexed by (1 << length) | pattern.
    task automatic predict_key_tick(input logic k);
        string      tree = "??ETIANMSURWDKGOHVF?L?PJBXCYZQ??54?3???2???????16???????7???8?90";
        logic [5:0] idx;
        byte        sym;
        if (k) begin
            if (press_cnt != COUNT_SAT) press_cnt++;
            gap_cnt    = '0;
            letter_due = 1'b1;
            space_due  = 1'b1;
            key_held   = 1'b1;
        end else begin
            // release: append the symbol and restart the gap on this very tick
            if (key_held) begin
                if (sym_cnt < MAX_SYM) begin
                    sym_bits = {sym_bits[3:0], press_cnt >= cfg_model.dot_limit};
                    sym_cnt++;
                end else begin
                    sym_cnt = MAX_SYM + 1;
                end
                press_cnt = '0;
                gap_cnt   = '0;
                key_held  = 1'b0;
            end
            if (gap_cnt != COUNT_SAT) gap_cnt++;
            // letter wins over space; the space then follows on a later tick
            if (gap_cnt > cfg_model.letter_gap && letter_due) begin
                if (sym_cnt == 0 || sym_cnt > MAX_SYM) begin
                    chars_due.push_back(mkd_pkg::CH_UNKNOWN);
                end else begin
                    idx = 6'(1 << sym_cnt) | 6'(sym_bits);
                    sym = tree.getc(idx);
                    chars_due.push_back(sym[6:0]);
                end
                sym_bits   = '0;
                sym_cnt    = 0;
                letter_due = 1'b0;
            end else if (gap_cnt > cfg_model.word_gap && space_due) begin
                chars_due.push_back(mkd_pkg::CH_SPACE);
                space_due = 1'b0;
            end
        end
    endtask

    // Offer one key sample, idling at random beforehand, and hold it until taken
    task automatic send_key(input logic k);
        while (gaps_on && $urandom_range(99) < 9) begin
            r_push <= 1'b0;
            r_key  <= 1'($urandom);     // junk while idle, must be ignored
            @(posedge i_clk);
        end
        r_push <= 1'b1;
        r_key  <= k;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        predict_key_tick(k);
        items_sent++;
    endtask

    task automatic key_run(input logic k, input int n);
        repeat (n) send_key(k);
    endtask

    // Drop the input, wait for every predicted character, then let the
    // pipeline go quiet before anything touches the registers.
    task automatic settle();
        r_push <= 1'b0;
        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access; psel is left high so transfers may run back to back
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        r_psel    <= 1'b1;
        r_penable <= 1'b0;
        r_pwrite  <= 1'b1;
        r_paddr   <= addr;
        r_pwdata  <= data;
        @(posedge i_clk);
        r_penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == reg_addr(mkd_pkg::REG_DOT_LIMIT))
            cfg_model.dot_limit = data[15:0];
        else if (addr == reg_addr(mkd_pkg::REG_LETTER_GAP))
            cfg_model.letter_gap = data[15:0];
        else if (addr == reg_addr(mkd_pkg::REG_WORD_GAP))
            cfg_model.word_gap = data[15:0];
    endtask

    task automatic apb_read_check(input mkd_pkg::t_reg_idx r, input logic [15:0] want);
        r_psel    <= 1'b1;
        r_penable <= 1'b0;
        r_pwrite  <= 1'b0;
        r_paddr   <= reg_addr(r);
        @(posedge i_clk);
        r_penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'h0000, want}) begin
            $error("%s: expected %0d, actual %0d", r.name(), want, prdata);
            mismatches++;
        end
    endtask

    // Read every register back against the predicted values, then park the bus
    task automatic check_registers();
        apb_read_check(mkd_pkg::REG_DOT_LIMIT,  cfg_model.dot_limit);
        apb_read_check(mkd_pkg::REG_LETTER_GAP, cfg_model.letter_gap);
        apb_read_check(mkd_pkg::REG_WORD_GAP,   cfg_model.word_gap);
        r_psel    <= 1'b0;
        r_penable <= 1'b0;
    endtask

    // Junk in the upper half checks that only the low 16 bits are kept
    task automatic set_config(input logic [15:0] dl, input logic [15:0] lg,
                              input logic [15:0] wg);
        settle();
        apb_write(reg_addr(mkd_pkg::REG_DOT_LIMIT),  {16'($urandom), dl});
        apb_write(reg_addr(mkd_pkg::REG_LETTER_GAP), {16'($urandom), lg});
        apb_write(reg_addr(mkd_pkg::REG_WORD_GAP),   {16'($urandom), wg});
        check_registers();
        settings_used++;
    endtask

    // Key one letter with random symbols, timed from the current settings
    task automatic send_letter();
        int   n;
        int   press;
        int   dl;
        int   lg;
        logic dash;
        dl = cfg_model.dot_limit;
        lg = cfg_model.letter_gap;
        n  = ($urandom_range(9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            dash = 1'($urandom);
            if (dl > 8)
                press = $urandom_range(1, 4);
            else if (dash || dl < 2)
                press = $urandom_range((dl == 0) ? 1 : dl, dl + 3);
            else
                press = $urandom_range(1, dl - 1);
            key_run(1'b1, press);
            if (i < n - 1)
                key_run(1'b0, (lg > 8) ? $urandom_range(1, 6)
                                       : $urandom_range(1, (lg < 1) ? 1 : lg));
        end
        key_run(1'b0, (lg > 8) ? $urandom_range(1, 20) : $urandom_range(lg + 1, lg + 12));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_values();
        check_registers();
    endtask

    // Default dot limit: 199 ticks is a dot, 200 a dash; shorten the gaps
    // before the release so that 'A' and a space follow quickly
    task automatic test_default_timing();
        key_run(1'b1, 199);
        key_run(1'b0, 3);
        key_run(1'b1, 200);
        set_config(mkd_pkg::DOT_LIMIT_RST, 16'd2, 16'd5);
        key_run(1'b0, 6);
    endtask

    task automatic test_symbols();
        set_config(16'd3, 16'd2, 16'd5);
        key_run(1'b1, 2);                   // dot just under the limit: E, space
        key_run(1'b0, 6);
        key_run(1'b1, 3);                   // dash on the limit: T, no space
        key_run(1'b0, 3);
        for (int i = 0; i < 5; i++) begin   // five dashes, longest inner gap: 0
            key_run(1'b1, 3);
            key_run(1'b0, (i < 4) ? 2 : 3);
        end
        for (int i = 0; i < 6; i++) begin   // six dots overflow: ?
            key_run(1'b1, 1);
            key_run(1'b0, (i < 5) ? 1 : 6);
        end
        key_run(1'b1, 1);                   // dot dot dash dash spells nothing
        key_run(1'b0, 1);
        key_run(1'b1, 2);
        key_run(1'b0, 2);
        key_run(1'b1, 4);
        key_run(1'b0, 1);
        key_run(1'b1, 3);
        key_run(1'b0, 6);
    endtask

    task automatic test_gap_corners();
        set_config(16'd3, 16'd2, 16'd2);    // letter and space fall due together
        key_run(1'b1, 1);
        key_run(1'b0, 4);
        set_config(16'd0, 16'd0, 16'd2);    // every press a dash, letter at once
        key_run(1'b1, 1);
        key_run(1'b0, 4);
        set_config(16'd1, 16'd3, 16'd0);    // space ahead of the letter
        key_run(1'b1, 1);
        key_run(1'b0, 5);
    endtask

    task automatic test_spare_address();
        settle();
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        check_registers();
    endtask

    // Stall the receiver while keying fast enough to fill the block, then
    // pause the sender until everything has drained
    task automatic test_backpressure();
        set_config(16'd1, 16'd0, 16'd0);
        rx_hold = 400;
        repeat (60) begin
            send_key(1'b1);
            key_run(1'b0, 2);
        end
        settle();
    endtask

    task automatic test_random();
        int unsigned start;
        int unsigned phase_end;
        int          phase;
        logic [15:0] dl;
        logic [15:0] lg;
        logic [15:0] wg;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            dl = 16'($urandom_range(0, 6));
            lg = 16'($urandom_range(0, 6));
            wg = 16'($urandom_range(0, 12));
            case ($urandom_range(7))
                0:       dl = COUNT_SAT;
                1:       lg = COUNT_SAT;
                2:       wg = COUNT_SAT;
                default: ;
            endcase
            set_config(dl, lg, wg);
            gaps_on   = (phase != 3);       // one phase runs flat out
            phase_end = items_sent + $urandom_range(80, 160);
            while (items_sent < phase_end) begin
                case ($urandom_range(9))
                    0:       repeat ($urandom_range(1, 12)) send_key(1'($urandom));
                    1:       key_run(1'($urandom), $urandom_range(1, 30));
                    default: send_letter();
                endcase
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------ processes

    // Result side: pop at random, honour a requested hold-off, check in order
    initial begin
        logic [6:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && r_pop && !empty) begin
                if (chars_due.size() == 0) begin
                    $error("char_code: expected none, actual %0d", o_char_code);
                    mismatches++;
                end else begin
                    want = chars_due.pop_front();
                    chars_checked++;
                    if (o_char_code !== want) begin
                        $error("char_code: expected %0d, actual %0d", want, o_char_code);
                        mismatches++;
                    end
                end
            end
            if (rx_hold > 0) begin
                r_pop <= 1'b0;
                rx_hold--;
            end else begin
                r_pop <= !(gaps_on && $urandom_range(99) < 9);
            end
        end
    end

    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        cfg_model  = '{dot_limit:  mkd_pkg::DOT_LIMIT_RST,
                       letter_gap: mkd_pkg::LETTER_GAP_RST,
                       word_gap:   mkd_pkg::WORD_GAP_RST};
        press_cnt  = '0;
        gap_cnt    = '0;
        key_held   = 1'b0;
        letter_due = 1'b0;
        space_due  = 1'b0;
        sym_bits   = '0;
        sym_cnt    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_default_timing();
        test_symbols();
        test_gap_corners();
        test_spare_address();
        test_backpressure();
        test_random();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d key samples and %0d decoded characters", items_sent,
                 chars_checked);
        $display("over %0d register settings, with %0d cycles of input back-pressure",
                 settings_used, full_stalls);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
